// ----- rtl/tau_pkg.sv -----
package tau_pkg;

    localparam int MANT_W    = 64;
    localparam int EXP_W     = 8;
    localparam int RAW_EXP_W = 10;
    localparam int SHIFT_W   = 4;
    localparam int AMT_W     = 16;

    localparam logic signed [RAW_EXP_W-1:0] EXP_MIN = -RAW_EXP_W'(128);
    localparam logic signed [RAW_EXP_W-1:0] EXP_MAX = '0;

    typedef enum logic [2:0] {
        OP_CMP    = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_INC    = 3'd3,
        OP_TRUNC  = 3'd4,
        OP_BEHEAD = 3'd5
    } op_t;

    typedef logic [1:0] ord_t;
    localparam ord_t ORD_LESS    = 2'd0;
    localparam ord_t ORD_EQUAL   = 2'd1;
    localparam ord_t ORD_GREATER = 2'd2;

    // where each result digit comes from before justification
    typedef enum logic [3:0] {
        MODE_ZERO,
        MODE_A,
        MODE_B,
        MODE_MADD,
        MODE_SSUB,
        MODE_WSUB,
        MODE_INC,
        MODE_TRUNC,
        MODE_BEHEAD
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  inc_en;
        logic  bh_zero;
    } ctrl_t;

    typedef struct packed {
        logic [2:0]              req_type;
        logic                    a_sign;
        logic signed [EXP_W-1:0] a_exp;
        logic [MANT_W-1:0]       a_mantissa;
        logic                    b_sign;
        logic signed [EXP_W-1:0] b_exp;
        logic [MANT_W-1:0]       b_mantissa;
        logic [SHIFT_W-1:0]      shift_amount;
        logic [AMT_W-1:0]        amount;
    } req_t;

    typedef struct packed {
        logic                    r_sign;
        logic signed [EXP_W-1:0] r_exp;
        logic [MANT_W-1:0]       r_mantissa;
        ord_t                    order;
        logic                    overflow;
    } rsp_t;

endpackage

// ----- rtl/tau_if.sv -----
interface tau_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tau_classify.sv -----
module tau_classify #(
    parameter int DIGITS     = 4,
    parameter int DIGIT_BITS = 16,
    parameter int IDX_W      = 3
) (
    input  tau_pkg::op_t                                   op,
    input  logic                                           a_sign,
    input  logic signed [tau_pkg::EXP_W-1:0]               a_exp,
    input  logic [DIGITS-1:0][DIGIT_BITS-1:0]              a_d,
    input  logic                                           b_sign,
    input  logic signed [tau_pkg::EXP_W-1:0]               b_exp,
    input  logic [DIGITS-1:0][DIGIT_BITS-1:0]              b_d,
    input  logic [tau_pkg::SHIFT_W-1:0]                    rs,
    input  logic [tau_pkg::AMT_W-1:0]                      amount,
    output tau_pkg::ctrl_t                                 ctrl,
    output logic                                           sign,
    output logic signed [tau_pkg::RAW_EXP_W-1:0]           exp,
    output logic                                           ov,
    output tau_pkg::ord_t                                  order,
    output logic [IDX_W-1:0]                               gap,
    output logic [IDX_W-1:0]                               sidx,
    output logic [IDX_W-1:0]                               tgt,
    output logic [IDX_W-1:0]                               cut
);

    localparam int XW = tau_pkg::RAW_EXP_W;
    localparam logic signed [XW-1:0] DIG_X = XW'(DIGITS);

    logic [DIGITS-1:0] eq;
    logic [DIGITS-1:0] lt;

    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_cmp
            assign eq[gi] = (a_d[gi] == b_d[gi]);
            assign lt[gi] = (a_d[gi] < b_d[gi]);
        end
    endgenerate

    function automatic logic [IDX_W-1:0] sat_idx(input logic signed [XW-1:0] g);
        sat_idx = (g >= DIG_X) ? IDX_W'(DIGITS) : IDX_W'(g);
    endfunction

    function automatic tau_pkg::ord_t flip(input tau_pkg::ord_t o);
        if (o == tau_pkg::ORD_LESS)
            flip = tau_pkg::ORD_GREATER;
        else if (o == tau_pkg::ORD_GREATER)
            flip = tau_pkg::ORD_LESS;
        else
            flip = o;
    endfunction

    always_comb
    begin
        logic                   found;
        logic                   dlt;
        logic [IDX_W-1:0]       last_nz;
        logic                   az;
        logic                   bz;
        logic                   bs_eff;
        logic signed [XW-1:0]   ae;
        logic signed [XW-1:0]   be;
        logic signed [XW-1:0]   gap_ab;
        logic signed [XW-1:0]   gap_ba;
        logic signed [XW-1:0]   lead;
        logic signed [17:0]     cut_full;
        logic [5:0]             inc_sum;
        tau_pkg::ord_t          mag;
        tau_pkg::ord_t          full;

        found   = 1'b0;
        dlt     = 1'b0;
        sidx    = '0;
        last_nz = '0;
        for (int j = 0; j < DIGITS; j++)
        begin
            if (!found && !eq[j])
            begin
                found = 1'b1;
                dlt   = lt[j];
                sidx  = IDX_W'(j);
            end
        end
        for (int j = 1; j < DIGITS; j++)
        begin
            if (a_d[j] != '0)
                last_nz = IDX_W'(j);
        end

        az     = (a_d[0] == '0);
        bz     = (b_d[0] == '0);
        bs_eff = b_sign ^ (op == tau_pkg::OP_SUB);
        ae     = XW'(a_exp);
        be     = XW'(b_exp);
        gap_ab = ae - be;
        gap_ba = be - ae;

        if (ae != be)
            mag = (ae < be) ? tau_pkg::ORD_LESS : tau_pkg::ORD_GREATER;
        else if (found)
            mag = dlt ? tau_pkg::ORD_LESS : tau_pkg::ORD_GREATER;
        else
            mag = tau_pkg::ORD_EQUAL;

        if (az)
            full = bz ? tau_pkg::ORD_EQUAL
                      : (b_sign ? tau_pkg::ORD_GREATER : tau_pkg::ORD_LESS);
        else if (bz)
            full = a_sign ? tau_pkg::ORD_LESS : tau_pkg::ORD_GREATER;
        else if (a_sign == b_sign)
            full = a_sign ? flip(mag) : mag;
        else
            full = a_sign ? tau_pkg::ORD_LESS : tau_pkg::ORD_GREATER;

        lead     = (ae < 0) ? -ae : '0;
        cut_full = $signed({2'b00, amount}) - 18'(lead);
        inc_sum  = 6'(last_nz) + 6'(rs);

        ctrl  = '{mode: tau_pkg::MODE_ZERO, inc_en: 1'b0, bh_zero: 1'b0};
        sign  = 1'b0;
        exp   = '0;
        ov    = 1'b0;
        order = tau_pkg::ORD_LESS;   // arithmetic results report zero here
        gap   = '0;
        tgt   = '0;
        cut   = '0;

        unique case (op) inside
            tau_pkg::OP_CMP:
            begin
                order = full;
            end
            tau_pkg::OP_ADD, tau_pkg::OP_SUB:
            begin
                if (bz)
                begin
                    ctrl.mode = tau_pkg::MODE_A;
                    sign      = a_sign;
                    exp       = ae;
                end
                else if (az)
                begin
                    ctrl.mode = tau_pkg::MODE_B;
                    sign      = bs_eff;
                    exp       = be;
                end
                else if (a_sign == bs_eff)
                begin
                    if (ae < be)
                    begin
                        ctrl.mode = tau_pkg::MODE_B;
                        sign      = bs_eff;
                        exp       = be;
                    end
                    else
                    begin
                        ctrl.mode = tau_pkg::MODE_MADD;
                        sign      = a_sign;
                        exp       = ae;
                        gap       = sat_idx(gap_ab);
                        ov        = (gap_ab >= DIG_X);
                    end
                end
                else if (mag == tau_pkg::ORD_GREATER)
                begin
                    sign = a_sign;
                    if (be < ae)
                    begin
                        ctrl.mode = tau_pkg::MODE_A;
                        exp       = ae;
                    end
                    else
                    begin
                        ctrl.mode = tau_pkg::MODE_SSUB;
                        exp       = ae - XW'(sidx);
                    end
                end
                else
                begin
                    ctrl.mode = tau_pkg::MODE_WSUB;
                    sign      = bs_eff;
                    exp       = be;
                    gap       = sat_idx(gap_ba);
                    ov        = (gap_ba >= DIG_X);
                end
            end
            tau_pkg::OP_INC:
            begin
                ctrl.mode = tau_pkg::MODE_INC;
                if (az)
                begin
                    exp         = -$signed(XW'(rs));
                    ctrl.inc_en = 1'b1;
                end
                else
                begin
                    sign = a_sign;
                    exp  = ae;
                    if (inc_sum >= 6'(DIGITS))
                        ov = 1'b1;
                    else
                    begin
                        ctrl.inc_en = 1'b1;
                        tgt         = IDX_W'(inc_sum);
                    end
                end
            end
            tau_pkg::OP_TRUNC:
            begin
                if (cut_full > 0)
                begin
                    ctrl.mode = tau_pkg::MODE_TRUNC;
                    sign      = a_sign;
                    exp       = ae;
                    cut       = (cut_full[16:0] >= 17'(DIGITS)) ? IDX_W'(DIGITS)
                                                                 : IDX_W'(cut_full);
                end
            end
            tau_pkg::OP_BEHEAD:
            begin
                ctrl.mode    = tau_pkg::MODE_BEHEAD;
                ctrl.bh_zero = (ae == '0);
                sign         = a_sign;
                exp          = ae + XW'(1);
            end
            default:
            begin
                ctrl.mode = tau_pkg::MODE_ZERO;
            end
        endcase
    end

endmodule

// ----- rtl/tau_lane.sv -----
module tau_lane #(
    parameter int DIGITS     = 4,
    parameter int DIGIT_BITS = 16,
    parameter int IDX_W      = 3,
    parameter int LANE       = 0
) (
    input  tau_pkg::ctrl_t                      ctrl,
    input  logic [DIGITS-1:0][DIGIT_BITS-1:0]   a_d,
    input  logic [DIGITS-1:0][DIGIT_BITS-1:0]   b_d,
    input  logic [IDX_W-1:0]                    gap,
    input  logic [IDX_W-1:0]                    sidx,
    input  logic [IDX_W-1:0]                    tgt,
    input  logic [IDX_W-1:0]                    cut,
    input  logic [DIGIT_BITS-1:0]               amt,
    output logic [DIGIT_BITS-1:0]               digit
);

    localparam logic [IDX_W-1:0] J = IDX_W'(LANE);

    always_comb
    begin
        logic [DIGIT_BITS-1:0] b_sh;
        logic [DIGIT_BITS-1:0] a_ss;
        logic [DIGIT_BITS-1:0] b_ss;

        b_sh = '0;
        a_ss = '0;
        b_ss = '0;
        // b digit that lines up with this lane after the exponent gap
        for (int k = 0; k <= LANE; k++)
        begin
            if (gap == IDX_W'(LANE - k))
                b_sh = b_d[k];
        end
        // digits moved up past the common prefix
        for (int k = LANE; k < DIGITS; k++)
        begin
            if (sidx == IDX_W'(k - LANE))
            begin
                a_ss = a_d[k];
                b_ss = b_d[k];
            end
        end

        case (ctrl.mode)
            tau_pkg::MODE_A:      digit = a_d[LANE];
            tau_pkg::MODE_B:      digit = b_d[LANE];
            tau_pkg::MODE_MADD:
                digit = (gap > J) ? a_d[LANE] :
                        (gap == J) ? a_d[LANE] + b_d[0] : b_sh;
            tau_pkg::MODE_SSUB:   digit = (LANE == 0) ? a_ss - b_ss : a_ss;
            tau_pkg::MODE_WSUB:
                digit = (gap > J) ? b_d[LANE] :
                        (gap == J) ? b_d[LANE] - a_d[0] : '0;
            tau_pkg::MODE_INC:
                digit = a_d[LANE] + ((ctrl.inc_en && tgt == J) ? amt : '0);
            tau_pkg::MODE_TRUNC:  digit = (cut > J) ? a_d[LANE] : '0;
            tau_pkg::MODE_BEHEAD:
                digit = (LANE == 0 && ctrl.bh_zero) ? '0 : a_d[LANE];
            default:              digit = '0;
        endcase
    end

endmodule

// ----- rtl/tau_justify.sv -----
module tau_justify #(
    parameter int DIGITS     = 4,
    parameter int DIGIT_BITS = 16,
    parameter int IDX_W      = 3
) (
    input  logic [DIGITS-1:0][DIGIT_BITS-1:0]         raw_d,
    input  logic                                      raw_sign,
    input  logic signed [tau_pkg::RAW_EXP_W-1:0]      raw_exp,
    input  logic                                      raw_ov,
    output logic                                      r_sign,
    output logic signed [tau_pkg::EXP_W-1:0]          r_exp,
    output logic [tau_pkg::MANT_W-1:0]                r_mantissa,
    output logic                                      overflow
);

    localparam int XW  = tau_pkg::RAW_EXP_W;
    localparam int FIT = (DIGITS * DIGIT_BITS <= tau_pkg::MANT_W) ? DIGITS
                                                                 : tau_pkg::MANT_W / DIGIT_BITS;
    localparam int REM = tau_pkg::MANT_W - FIT * DIGIT_BITS;

    logic [DIGITS-1:0][DIGIT_BITS-1:0] out_d;

    always_comb
    begin
        logic                 found;
        logic [IDX_W-1:0]     s;
        logic signed [XW-1:0] e;

        found = 1'b0;
        s     = '0;
        for (int j = 0; j < DIGITS; j++)
        begin
            if (!found && raw_d[j] != '0)
            begin
                found = 1'b1;
                s     = IDX_W'(j);
            end
        end
        for (int j = 0; j < DIGITS; j++)
        begin
            out_d[j] = '0;
            for (int k = j; k < DIGITS; k++)
            begin
                if (s == IDX_W'(k - j))
                    out_d[j] = raw_d[k];
            end
        end

        e        = raw_exp - XW'(s);
        r_sign   = raw_sign;
        overflow = raw_ov;
        if (!found)
        begin
            out_d  = '0;
            r_sign = 1'b0;
            e      = '0;
        end
        if (e < tau_pkg::EXP_MIN)
        begin
            e        = tau_pkg::EXP_MIN;
            overflow = 1'b1;
        end
        if (e > tau_pkg::EXP_MAX)
        begin
            e        = tau_pkg::EXP_MAX;
            overflow = 1'b1;
        end
        r_exp = tau_pkg::EXP_W'(e);
    end

    genvar gi;
    generate
        for (gi = 0; gi < FIT; gi++)
        begin : g_pack
            assign r_mantissa[tau_pkg::MANT_W-1-gi*DIGIT_BITS -: DIGIT_BITS] = out_d[gi];
        end
        if (REM > 0)
        begin : g_pad
            assign r_mantissa[REM-1:0] = '0;
        end
    endgenerate

endmodule

// ----- rtl/tumbler_arithmetic_unit.sv -----
// Tumbler arithmetic unit.
// req (tau_if of tau_pkg::req_t) carries one operation per transfer: compare,
// add, subtract, increment, truncate or behead on operands a and b. rsp
// (tau_if of tau_pkg::rsp_t) returns exactly one result per operation, in order.
// Each digit position has its own lane; a classify stage finds exponent gaps,
// the first differing digit and the increment position, and a justify stage
// shifts out leading zero digits and clamps the exponent.
// Structure: four register stages (input, classify, lanes, justify/output);
// each stage is a register with its own valid bit. Throughput: one operation
// per cycle while rsp.ready is high and the pipeline does not stall.
// Stall: while rsp.ready is low the result holds; earlier stages keep taking
// work until every stage is full, then req.ready drops.
// Reset: rst_n clears all valid bits; req.ready is high right after reset.
module tumbler_arithmetic_unit #(
    parameter int DIGITS     = 4,
    parameter int DIGIT_BITS = 16
) (
    input logic    clk,
    input logic    rst_n,
    tau_if.sink    req,
    tau_if.source  rsp
);

    localparam int IDX_W = $clog2(DIGITS + 1);
    localparam int XW    = tau_pkg::RAW_EXP_W;
    localparam int MW    = tau_pkg::MANT_W;

    typedef logic [DIGITS-1:0][DIGIT_BITS-1:0] dvec_t;

    // unpack, forcing an operand with a zero first digit to exact zero
    dvec_t ua_d;
    dvec_t ub_d;
    logic  ua_zero;
    logic  ub_zero;

    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_unpack
            if ((gi + 1) * DIGIT_BITS <= MW)
            begin : g_in
                assign ua_d[gi] = req.data.a_mantissa[MW-1-gi*DIGIT_BITS -: DIGIT_BITS];
                assign ub_d[gi] = req.data.b_mantissa[MW-1-gi*DIGIT_BITS -: DIGIT_BITS];
            end
            else
            begin : g_out
                assign ua_d[gi] = '0;
                assign ub_d[gi] = '0;
            end
        end
    endgenerate

    assign ua_zero = (ua_d[0] == '0);
    assign ub_zero = (ub_d[0] == '0);

    // stage 1: operands
    logic                                 v1_reg;
    tau_pkg::op_t                         s1_op_reg;
    logic                                 s1_a_sign_reg;
    logic signed [tau_pkg::EXP_W-1:0]     s1_a_exp_reg;
    dvec_t                                s1_a_d_reg;
    logic                                 s1_b_sign_reg;
    logic signed [tau_pkg::EXP_W-1:0]     s1_b_exp_reg;
    dvec_t                                s1_b_d_reg;
    logic [tau_pkg::SHIFT_W-1:0]          s1_rs_reg;
    logic [tau_pkg::AMT_W-1:0]            s1_amount_reg;

    // stage 2: classified operation
    logic                                 v2_reg;
    tau_pkg::ctrl_t                       s2_ctrl_reg;
    logic                                 s2_sign_reg;
    logic signed [XW-1:0]                 s2_exp_reg;
    logic                                 s2_ov_reg;
    tau_pkg::ord_t                        s2_order_reg;
    logic [IDX_W-1:0]                     s2_gap_reg;
    logic [IDX_W-1:0]                     s2_sidx_reg;
    logic [IDX_W-1:0]                     s2_tgt_reg;
    logic [IDX_W-1:0]                     s2_cut_reg;
    logic [DIGIT_BITS-1:0]                s2_amt_reg;
    dvec_t                                s2_a_d_reg;
    dvec_t                                s2_b_d_reg;

    // stage 3: raw digits
    logic                                 v3_reg;
    dvec_t                                s3_d_reg;
    logic                                 s3_sign_reg;
    logic signed [XW-1:0]                 s3_exp_reg;
    logic                                 s3_ov_reg;
    tau_pkg::ord_t                        s3_order_reg;

    // output register
    logic                                 vo_reg;
    tau_pkg::rsp_t                        out_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_o;

    assign rdy_o     = !vo_reg || rsp.ready;
    assign rdy3      = !v3_reg || rdy_o;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req.ready = rdy1;
    assign rsp.valid = vo_reg;
    assign rsp.data  = out_reg;

    // classify
    tau_pkg::ctrl_t        c_ctrl;
    logic                  c_sign;
    logic signed [XW-1:0]  c_exp;
    logic                  c_ov;
    tau_pkg::ord_t         c_order;
    logic [IDX_W-1:0]      c_gap;
    logic [IDX_W-1:0]      c_sidx;
    logic [IDX_W-1:0]      c_tgt;
    logic [IDX_W-1:0]      c_cut;

    tau_classify #(
        .DIGITS     (DIGITS),
        .DIGIT_BITS (DIGIT_BITS),
        .IDX_W      (IDX_W)
    ) u_classify (
        .op     (s1_op_reg),
        .a_sign (s1_a_sign_reg),
        .a_exp  (s1_a_exp_reg),
        .a_d    (s1_a_d_reg),
        .b_sign (s1_b_sign_reg),
        .b_exp  (s1_b_exp_reg),
        .b_d    (s1_b_d_reg),
        .rs     (s1_rs_reg),
        .amount (s1_amount_reg),
        .ctrl   (c_ctrl),
        .sign   (c_sign),
        .exp    (c_exp),
        .ov     (c_ov),
        .order  (c_order),
        .gap    (c_gap),
        .sidx   (c_sidx),
        .tgt    (c_tgt),
        .cut    (c_cut)
    );

    // lanes
    dvec_t lane_d;

    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_lane
            tau_lane #(
                .DIGITS     (DIGITS),
                .DIGIT_BITS (DIGIT_BITS),
                .IDX_W      (IDX_W),
                .LANE       (gi)
            ) u_lane (
                .ctrl  (s2_ctrl_reg),
                .a_d   (s2_a_d_reg),
                .b_d   (s2_b_d_reg),
                .gap   (s2_gap_reg),
                .sidx  (s2_sidx_reg),
                .tgt   (s2_tgt_reg),
                .cut   (s2_cut_reg),
                .amt   (s2_amt_reg),
                .digit (lane_d[gi])
            );
        end
    endgenerate

    // justify and clamp
    logic                              j_sign;
    logic signed [tau_pkg::EXP_W-1:0]  j_exp;
    logic [MW-1:0]                     j_mant;
    logic                              j_ov;

    tau_justify #(
        .DIGITS     (DIGITS),
        .DIGIT_BITS (DIGIT_BITS),
        .IDX_W      (IDX_W)
    ) u_justify (
        .raw_d      (s3_d_reg),
        .raw_sign   (s3_sign_reg),
        .raw_exp    (s3_exp_reg),
        .raw_ov     (s3_ov_reg),
        .r_sign     (j_sign),
        .r_exp      (j_exp),
        .r_mantissa (j_mant),
        .overflow   (j_ov)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= req.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_o)
                vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_op_reg     <= tau_pkg::op_t'(req.data.req_type);
            s1_a_sign_reg <= ua_zero ? 1'b0 : req.data.a_sign;
            s1_a_exp_reg  <= ua_zero ? '0 : req.data.a_exp;
            s1_a_d_reg    <= ua_zero ? '0 : ua_d;
            s1_b_sign_reg <= ub_zero ? 1'b0 : req.data.b_sign;
            s1_b_exp_reg  <= ub_zero ? '0 : req.data.b_exp;
            s1_b_d_reg    <= ub_zero ? '0 : ub_d;
            s1_rs_reg     <= req.data.shift_amount;
            s1_amount_reg <= req.data.amount;
        end
        if (rdy2)
        begin
            s2_ctrl_reg  <= c_ctrl;
            s2_sign_reg  <= c_sign;
            s2_exp_reg   <= c_exp;
            s2_ov_reg    <= c_ov;
            s2_order_reg <= c_order;
            s2_gap_reg   <= c_gap;
            s2_sidx_reg  <= c_sidx;
            s2_tgt_reg   <= c_tgt;
            s2_cut_reg   <= c_cut;
            s2_amt_reg   <= DIGIT_BITS'(s1_amount_reg);
            s2_a_d_reg   <= s1_a_d_reg;
            s2_b_d_reg   <= s1_b_d_reg;
        end
        if (rdy3)
        begin
            s3_d_reg     <= lane_d;
            s3_sign_reg  <= s2_sign_reg;
            s3_exp_reg   <= s2_exp_reg;
            s3_ov_reg    <= s2_ov_reg;
            s3_order_reg <= s2_order_reg;
        end
        if (rdy_o)
        begin
            out_reg.r_sign     <= j_sign;
            out_reg.r_exp      <= j_exp;
            out_reg.r_mantissa <= j_mant;
            out_reg.order      <= s3_order_reg;
            out_reg.overflow   <= j_ov;
        end
    end

    // a compare reporting equal or greater carries no tumbler and no overflow
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.order != tau_pkg::ORD_LESS |->
            rsp.data.r_mantissa == '0 && !rsp.data.overflow)
        else $error("compare result carries tumbler bits");

    // a zero first digit means exact zero
    a_zero_exact: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.r_mantissa[MW-1 -: DIGIT_BITS] == '0 |->
            rsp.data.r_exp == '0 && !rsp.data.r_sign && rsp.data.r_mantissa == '0)
        else $error("zero result not canonical");

    // a finished item in the lane stage is not lost while the output stalls
    a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy_o |=> v3_reg && $stable(s3_d_reg))
        else $error("lane stage dropped an item under stall");

endmodule
